### design/shap_pkg.sv
`default_nettype none

package shap_pkg;

  // Packet layout
  localparam int HEADER_BYTES = 4;
  localparam int REPORT_BYTES = 10;
  localparam int ROOT_STEPS   = 16;

  // Largest magnitude the square root can give from three 16-bit axes
  localparam logic [15:0] MAG_MAX = 16'd56755;

  // Configuration register indexes
  localparam int          CFG_IDX_W          = 8;
  localparam logic [7:0]  REG_REPORT_CHANNEL = 8'd0;
  localparam logic [7:0]  REG_ACCEL_ID       = 8'd1;

  // Axis select for the shared squarer
  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  typedef enum logic [1:0] {
    STAT_NEW       = 2'd0,
    STAT_BAD_LEN   = 2'd1,
    STAT_WRONG_CHN = 2'd2,
    STAT_NONE      = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PARSE,
    S_SQ_X,
    S_SQ_Y,
    S_SQ_Z,
    S_SQ_SUM,
    S_ROOT,
    S_DONE
  } state_t;

  typedef struct packed {
    logic       latch_in;
    logic       commit;
    logic       sq_load;
    logic [1:0] sq_sel;
    logic       acc_first;
    logic       acc_add;
    logic       root_init;
    logic       root_step;
    logic       load_result;
  } ctrl_cmd_t;

  typedef struct packed {
    logic emit_now;
    logic start_calc;
    logic out_free;
    logic root_last;
  } ctrl_sts_t;

endpackage

`default_nettype wire

### design/sensor_hub_accel_report_parser_core.sv
// Channel  Handshake           Payload
// in       in_valid/in_stall   rx_byte, first_byte
// out      out_valid/out_stall magnitude, status, accel_x, accel_y, accel_z
// cfg      cfg_valid/cfg_ready cfg_index, cfg_data
//
// A request is taken, then decoded and applied; the decode waits while an
// immediate result has nowhere to go. The byte that closes a matching report
// goes on to three squares through one shared multiplier plus the sum, the
// 16-step radix-2 square root unit and the load of the output register.
// Reset (rst, synchronous) clears the parser and returns the registers to
// channel 3, report id 1. A full output register stalls decode and result load.
`default_nettype none

module sensor_hub_accel_report_parser_core #(
  parameter int MAX_PACKET_BYTES = 512
) (
  input  wire                           clk,
  input  wire                           rst,
  input  wire                           in_valid,
  output logic                          in_stall,
  input  wire [7:0]                     rx_byte,
  input  wire                           first_byte,
  output logic                          out_valid,
  input  wire                           out_stall,
  output logic [15:0]                   magnitude,
  output logic [1:0]                    status,
  output logic signed [15:0]            accel_x,
  output logic signed [15:0]            accel_y,
  output logic signed [15:0]            accel_z,
  input  wire                           cfg_valid,
  output logic                          cfg_ready,
  input  wire [shap_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire [7:0]                     cfg_data
);
  import shap_pkg::*;

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  // Sequence each request: take, decode, and for a matching report
  // square, sum and root before loading the output register.
  shap_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Hold parser state, configuration, the arithmetic and the output register.
  shap_dpath #(
    .MAX_PACKET_BYTES (MAX_PACKET_BYTES)
  ) u_dpath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .rx_byte    (rx_byte),
    .first_byte (first_byte),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .magnitude  (magnitude),
    .status     (status),
    .accel_x    (accel_x),
    .accel_y    (accel_y),
    .accel_z    (accel_z),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

endmodule

`default_nettype wire

### design/shap_ctrl.sv
`default_nettype none

module shap_ctrl (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   in_valid,
  output logic                  in_stall,
  input  shap_pkg::ctrl_sts_t   sts,
  output shap_pkg::ctrl_cmd_t   cmd
);
  import shap_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_PARSE;
        end
      end
      S_PARSE: begin
        if (sts.start_calc) begin
          state_next = S_SQ_X;
        end else if (!sts.emit_now || sts.out_free) begin
          state_next = S_IDLE;
        end
      end
      S_SQ_X:   state_next = S_SQ_Y;
      S_SQ_Y:   state_next = S_SQ_Z;
      S_SQ_Z:   state_next = S_SQ_SUM;
      S_SQ_SUM: state_next = S_ROOT;
      S_ROOT: begin
        if (sts.root_last) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (sts.out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state)
      S_IDLE: begin
        in_stall     = 1'b0;
        cmd.latch_in = in_valid;
      end
      S_PARSE: begin
        // hold the byte while an immediate result has nowhere to go
        cmd.commit = !sts.emit_now || sts.out_free;
      end
      S_SQ_X: begin
        cmd.sq_load = 1'b1;
        cmd.sq_sel  = AXIS_X;
      end
      S_SQ_Y: begin
        cmd.sq_load   = 1'b1;
        cmd.sq_sel    = AXIS_Y;
        cmd.acc_first = 1'b1;
      end
      S_SQ_Z: begin
        cmd.sq_load = 1'b1;
        cmd.sq_sel  = AXIS_Z;
        cmd.acc_add = 1'b1;
      end
      S_SQ_SUM: begin
        cmd.root_init = 1'b1;
      end
      S_ROOT: begin
        cmd.root_step = 1'b1;
      end
      S_DONE: begin
        cmd.load_result = sts.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

### design/shap_dpath.sv
`default_nettype none

module shap_dpath #(
  parameter int MAX_PACKET_BYTES = 512
) (
  input  wire                           clk,
  input  wire                           rst,
  input  shap_pkg::ctrl_cmd_t           cmd,
  output shap_pkg::ctrl_sts_t           sts,
  input  wire [7:0]                     rx_byte,
  input  wire                           first_byte,
  output logic                          out_valid,
  input  wire                           out_stall,
  output logic [15:0]                   magnitude,
  output logic [1:0]                    status,
  output logic signed [15:0]            accel_x,
  output logic signed [15:0]            accel_y,
  output logic signed [15:0]            accel_z,
  input  wire                           cfg_valid,
  output logic                          cfg_ready,
  input  wire [shap_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire [7:0]                     cfg_data
);
  import shap_pkg::*;

  localparam int          PosW       = $clog2(MAX_PACKET_BYTES + 1);
  localparam logic [15:0] MaxLen     = 16'(MAX_PACKET_BYTES);
  localparam logic [14:0] MinLen     = 15'(HEADER_BYTES);
  localparam logic [14:0] MinRptLen  = 15'(HEADER_BYTES + REPORT_BYTES);
  localparam logic [3:0]  RptLast    = 4'(REPORT_BYTES - 1);
  localparam logic [3:0]  RootLast   = 4'(ROOT_STEPS - 1);

  // Configuration
  logic [7:0] report_channel;
  logic [7:0] accel_report_id;

  // Latched input byte
  logic [7:0] rx_q;
  logic       first_q;

  // Parser state
  logic [PosW-1:0] byte_position;
  logic [7:0]      length_low_byte;
  logic [14:0]     packet_length;
  logic [3:0]      report_position;
  logic            report_matches;
  logic [15:0]     axis_values [3];
  logic [15:0]     held_magnitude;
  logic            packet_finished;

  // Squarer and root unit
  logic [31:0] prod;
  logic [31:0] acc;
  logic [31:0] rad;
  logic [17:0] rem;
  logic [15:0] root;
  logic [3:0]  root_cnt;

  // Output register payload
  status_t status_q;

  // Decode of the latched byte
  logic            active;
  logic [PosW-1:0] pos;
  logic [PosW-1:0] pos_next;
  logic [3:0]      rp;
  logic [3:0]      rp_next;
  logic            match_next;
  logic            in_body;
  logic            axis_wr;
  logic [1:0]      axis_idx;
  logic [3:0]      axis_off;
  logic [14:0]     len_hdr;
  logic            emit_now;
  logic            start_calc;
  status_t         emit_code;

  logic [15:0] sq_in;
  logic [15:0] sq_abs;
  logic [31:0] sq;
  logic [19:0] rem_sh;
  logic [19:0] trial;
  logic [19:0] diff;
  logic        root_ge;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      report_channel  <= 8'd3;
      accel_report_id <= 8'd1;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_REPORT_CHANNEL: report_channel  <= cfg_data;
        REG_ACCEL_ID:       accel_report_id <= cfg_data;
        default:            ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      rx_q    <= rx_byte;
      first_q <= first_byte;
    end
  end

  always_comb begin
    active     = first_q || !packet_finished;
    pos        = first_q ? '0 : byte_position;
    pos_next   = pos + PosW'(1);
    rp         = first_q ? 4'd0 : report_position;
    len_hdr    = {rx_q[6:0], length_low_byte};
    in_body    = (pos >= PosW'(HEADER_BYTES));
    axis_wr    = in_body && (rp inside {[4'd4:4'd9]});
    axis_off   = rp - 4'd4;
    axis_idx   = axis_off[2:1];
    rp_next    = rp;
    match_next = first_q ? 1'b0 : report_matches;
    if (in_body) begin
      rp_next = (rp == RptLast) ? 4'd0 : rp + 4'd1;
      if (rp == 4'd0) begin
        match_next = (rx_q == accel_report_id);
      end
    end

    emit_now   = 1'b0;
    start_calc = 1'b0;
    emit_code  = STAT_NONE;
    if (active) begin
      if (pos == PosW'(0)) begin
        emit_now = 1'b0;
      end else if (pos == PosW'(1)) begin
        if (len_hdr < MinLen || {1'b0, len_hdr} > MaxLen) begin
          emit_now  = 1'b1;
          emit_code = STAT_BAD_LEN;
        end
      end else if (pos == PosW'(2)) begin
        if (rx_q != report_channel || packet_length < MinRptLen) begin
          emit_now  = 1'b1;
          emit_code = STAT_WRONG_CHN;
        end
      end else if (in_body && rp == RptLast && report_matches) begin
        start_calc = 1'b1;
      end else if (16'(pos_next) >= {1'b0, packet_length}) begin
        emit_now  = 1'b1;
        emit_code = STAT_NONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position   <= '0;
      length_low_byte <= '0;
      packet_length   <= '0;
      report_position <= '0;
      report_matches  <= 1'b0;
      axis_values[0]  <= '0;
      axis_values[1]  <= '0;
      axis_values[2]  <= '0;
      held_magnitude  <= '0;
      packet_finished <= 1'b1;
    end else begin
      if (cmd.commit && active) begin
        byte_position   <= pos_next;
        report_position <= rp_next;
        report_matches  <= match_next;
        packet_finished <= emit_now || start_calc;
        if (pos == PosW'(0)) begin
          length_low_byte <= rx_q;
        end
        if (pos == PosW'(1)) begin
          packet_length <= len_hdr;
        end
        if (axis_wr) begin
          if (axis_off[0]) begin
            axis_values[axis_idx][15:8] <= rx_q;
          end else begin
            axis_values[axis_idx][7:0] <= rx_q;
          end
        end
      end
      if (cmd.load_result) begin
        held_magnitude <= root;
      end
    end
  end

  // Shared squarer: one product per cycle, registered before the add
  always_comb begin
    sq_in  = axis_values[cmd.sq_sel];
    sq_abs = sq_in[15] ? (~sq_in + 16'd1) : sq_in;
    sq     = sq_abs * sq_abs;
  end

  // Radix-2 square root, one result bit per step
  always_comb begin
    rem_sh  = {rem, rad[31:30]};
    trial   = {2'b00, root, 2'b01};
    root_ge = (rem_sh >= trial);
    diff    = rem_sh - trial;
  end

  always_ff @(posedge clk) begin
    if (cmd.sq_load) begin
      prod <= sq;
    end
    if (cmd.acc_first) begin
      acc <= prod;
    end else if (cmd.acc_add) begin
      acc <= acc + prod;
    end
    if (cmd.root_init) begin
      rad      <= acc + prod;
      rem      <= '0;
      root     <= '0;
      root_cnt <= '0;
    end else if (cmd.root_step) begin
      rad      <= {rad[29:0], 2'b00};
      root_cnt <= root_cnt + 4'd1;
      if (root_ge) begin
        rem  <= diff[17:0];
        root <= {root[14:0], 1'b1};
      end else begin
        rem  <= rem_sh[17:0];
        root <= {root[14:0], 1'b0};
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((cmd.commit && emit_now) || cmd.load_result) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && emit_now) begin
      magnitude <= held_magnitude;
      status_q  <= emit_code;
      accel_x   <= '0;
      accel_y   <= '0;
      accel_z   <= '0;
    end else if (cmd.load_result) begin
      magnitude <= root;
      status_q  <= STAT_NEW;
      accel_x   <= axis_values[0];
      accel_y   <= axis_values[1];
      accel_z   <= axis_values[2];
    end
  end

  assign status = status_q;

  always_comb begin
    sts.emit_now   = emit_now;
    sts.start_calc = start_calc;
    sts.out_free   = !out_valid || !out_stall;
    sts.root_last  = (root_cnt == RootLast);
  end

endmodule

`default_nettype wire

### design/shap_checker.sv
`default_nettype none

module shap_checker (
  input wire                           clk,
  input wire                           rst,
  input wire                           in_valid,
  input wire                           in_stall,
  input wire                           out_valid,
  input wire                           out_stall,
  input wire [15:0]                    magnitude,
  input wire [1:0]                     status,
  input wire signed [15:0]             accel_x,
  input wire signed [15:0]             accel_y,
  input wire signed [15:0]             accel_z
);
  import shap_pkg::*;

  // Decode the byte before taking another
  a_stall_after_take: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken in the cycle after a take");

  a_axes_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != STAT_NEW |-> accel_x == 16'sd0 && accel_y == 16'sd0
      && accel_z == 16'sd0)
    else $error("axis values on a result without a sample");

  a_mag_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> magnitude <= MAG_MAX)
    else $error("magnitude out of range");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(magnitude) && $stable(status))
    else $error("stalled result changed");

endmodule

bind sensor_hub_accel_report_parser_core shap_checker u_shap_checker (.*);

`default_nettype wire
